// ===== rtl/core/vn_pkg.sv =====
`default_nettype none
package vn_pkg;

	// Default widths of the block.
	localparam int unsigned IN_WIDTH_DEF      = 16;
	localparam int unsigned OUT_FRAC_BITS_DEF = 14;

	// Width of each normalized output field.
	localparam int unsigned FIELD_W = 16;

	// Number of vector components.
	localparam int unsigned NUM_COMP = 3;

endpackage
`default_nettype wire

// ===== rtl/core/vn_sqrt_step.sv =====
`default_nettype none
// One digit of the scaled integer square root, followed by its pipeline register.
module vn_sqrt_step
	import vn_pkg::*;
#(
	parameter int unsigned IN_WIDTH      = IN_WIDTH_DEF,
	parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	parameter int unsigned IDX           = 0,
	parameter int unsigned SIDE_W        = 1
) (
	input  wire logic                                    clk,
	input  wire logic                                    en,
	input  wire logic [2*IN_WIDTH-1:0]                   s_in,
	input  wire logic [IN_WIDTH+OUT_FRAC_BITS-1:0]       root_in,
	input  wire logic [IN_WIDTH+OUT_FRAC_BITS+2:0]       rem_in,
	input  wire logic [SIDE_W-1:0]                       side_in,
	output logic      [2*IN_WIDTH-1:0]                   s_out,
	output logic      [IN_WIDTH+OUT_FRAC_BITS-1:0]       root_out,
	output logic      [IN_WIDTH+OUT_FRAC_BITS+2:0]       rem_out,
	output logic      [SIDE_W-1:0]                       side_out
);

	localparam int unsigned R_W  = IN_WIDTH + OUT_FRAC_BITS;
	localparam int unsigned RM_W = R_W + 3;

	logic [1:0]      pair;
	logic [RM_W-1:0] rem_sh;
	logic [RM_W-1:0] trial;
	logic            ge;
	logic [RM_W-1:0] rem_nx;
	logic [R_W-1:0]  root_nx;

	// The low digit pairs of the scaled sum are all zero.
	generate
		if (IDX >= OUT_FRAC_BITS) begin : g_pair
			assign pair = s_in[2*(IDX-OUT_FRAC_BITS) +: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end
	endgenerate

	always_comb begin
		rem_sh  = {rem_in[RM_W-3:0], pair};
		trial   = RM_W'({root_in, 2'b01});
		ge      = (rem_sh >= trial);
		rem_nx  = ge ? (rem_sh - trial) : rem_sh;
		root_nx = {root_in[R_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_out    <= s_in;
			root_out <= root_nx;
			rem_out  <= rem_nx;
			side_out <= side_in;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/vn_div_step.sv =====
`default_nettype none
// One quotient bit of the scaled restoring division, followed by its pipeline register.
module vn_div_step
	import vn_pkg::*;
#(
	parameter int unsigned IN_WIDTH      = IN_WIDTH_DEF,
	parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
	parameter int unsigned IDX           = 0
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [IN_WIDTH-1:0]                 mag_in,
	input  wire logic [IN_WIDTH+OUT_FRAC_BITS-1:0]   m_in,
	input  wire logic [IN_WIDTH+OUT_FRAC_BITS:0]     rem_in,
	input  wire logic [OUT_FRAC_BITS+1:0]            q_in,
	input  wire logic                                sat_in,
	output logic      [IN_WIDTH-1:0]                 mag_out,
	output logic      [IN_WIDTH+OUT_FRAC_BITS:0]     rem_out,
	output logic      [OUT_FRAC_BITS+1:0]            q_out,
	output logic                                     sat_out
);

	localparam int unsigned R_W = IN_WIDTH + OUT_FRAC_BITS;
	localparam int unsigned Q_W = OUT_FRAC_BITS + 2;
	localparam logic [Q_W-1:0] LIMIT = Q_W'(1) << OUT_FRAC_BITS;

	logic           dbit;
	logic [R_W:0]   rem_sh;
	logic           ge;
	logic [R_W:0]   rem_nx;
	logic [Q_W-1:0] q_sh;
	logic           sat_nx;

	// Dividend is the magnitude shifted up by twice the fraction width.
	generate
		if (IDX >= 2*OUT_FRAC_BITS) begin : g_bit
			assign dbit = mag_in[IDX-2*OUT_FRAC_BITS];
		end else begin : g_zero
			assign dbit = 1'b0;
		end
	endgenerate

	always_comb begin
		rem_sh = {rem_in[R_W-1:0], dbit};
		ge     = (rem_sh >= {1'b0, m_in});
		rem_nx = ge ? (rem_sh - {1'b0, m_in}) : rem_sh;
		q_sh   = {q_in[Q_W-2:0], ge};
		// Once the quotient passes the limit it stays clamped.
		sat_nx = sat_in | (q_sh > LIMIT);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_out <= mag_in;
			rem_out <= rem_nx;
			q_out   <= q_sh;
			sat_out <= sat_nx;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/vec3_normalize_top.sv =====
`default_nettype none
// Fully pipelined 3D vector normalizer. Each item is a signed vector (comp_x, comp_y, comp_z)
// and the result is its unit vector in signed fixed point with OUT_FRAC_BITS fraction bits,
// each component truncated toward zero and clamped to plus or minus one. The block accepts
// one item per cycle while the output is not stalled and returns one result per item, in
// order. The stages register the inputs, square them and sum, then take the root digits
// and the quotient bits (three dividers side by side), then register the output. The
// whole pipeline holds while a finished result is stalled at the output, so no item is
// lost or repeated. An all zero vector gives zero outputs with was_zero set.
module vec3_normalize_top
	import vn_pkg::*;
#(
	parameter int unsigned IN_WIDTH      = IN_WIDTH_DEF,
	parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       vec_valid,
	output logic                            vec_stall,
	input  wire logic signed [IN_WIDTH-1:0] comp_x,
	input  wire logic signed [IN_WIDTH-1:0] comp_y,
	input  wire logic signed [IN_WIDTH-1:0] comp_z,
	output logic                            unit_valid,
	input  wire logic                       unit_stall,
	output logic signed [FIELD_W-1:0]       unit_x,
	output logic signed [FIELD_W-1:0]       unit_y,
	output logic signed [FIELD_W-1:0]       unit_z,
	output logic                            was_zero
);

	localparam int unsigned R_W    = IN_WIDTH + OUT_FRAC_BITS;
	localparam int unsigned RM_W   = R_W + 3;
	localparam int unsigned S_W    = 2 * IN_WIDTH;
	localparam int unsigned D_W    = IN_WIDTH + 2 * OUT_FRAC_BITS;
	localparam int unsigned Q_W    = OUT_FRAC_BITS + 2;
	localparam int unsigned SIDE_W = NUM_COMP * IN_WIDTH + NUM_COMP + 1;
	localparam int unsigned NV     = R_W + D_W + 4;
	localparam logic [Q_W-1:0] LIMIT = Q_W'(1) << OUT_FRAC_BITS;

	// The pipeline advances unless a finished result is being held at the output.
	logic en;
	logic [NV-1:0] vld_q;

	assign en         = !(unit_valid && unit_stall);
	assign vec_stall  = !en;
	assign unit_valid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], vec_valid};
		end
	end

	// Stage 1: magnitudes and signs.
	logic [IN_WIDTH-1:0] comp_w [NUM_COMP];
	logic [IN_WIDTH-1:0] mag_s1 [NUM_COMP];
	logic [NUM_COMP-1:0] neg_s1;
	logic                zero_s1;

	assign comp_w[0] = comp_x;
	assign comp_w[1] = comp_y;
	assign comp_w[2] = comp_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_COMP; k++) begin
				neg_s1[k] <= comp_w[k][IN_WIDTH-1];
				// The most negative value negates to itself, which is its magnitude.
				mag_s1[k] <= comp_w[k][IN_WIDTH-1] ? (~comp_w[k] + 1'b1) : comp_w[k];
			end
			zero_s1 <= (comp_x == '0) && (comp_y == '0) && (comp_z == '0);
		end
	end

	// Stage 2: squares.
	logic [S_W-1:0]      sq_s2  [NUM_COMP];
	logic [IN_WIDTH-1:0] mag_s2 [NUM_COMP];
	logic [NUM_COMP-1:0] neg_s2;
	logic                zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_COMP; k++) begin
				sq_s2[k]  <= mag_s1[k] * mag_s1[k];
				mag_s2[k] <= mag_s1[k];
			end
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;
		end
	end

	// Stage 3: exact sum of squares.
	logic [S_W-1:0]    s_s3;
	logic [SIDE_W-1:0] side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s3    <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3 <= {zero_s2, neg_s2, mag_s2[2], mag_s2[1], mag_s2[0]};
		end
	end

	// Square root, one digit per stage, most significant first.
	logic [S_W-1:0]    s_c    [R_W+1];
	logic [R_W-1:0]    root_c [R_W+1];
	logic [RM_W-1:0]   rem_c  [R_W+1];
	logic [SIDE_W-1:0] side_c [R_W+1];

	assign s_c[0]    = s_s3;
	assign root_c[0] = '0;
	assign rem_c[0]  = '0;
	assign side_c[0] = side_s3;

	generate
		for (genvar g = 0; g < R_W; g++) begin : g_sqrt
			vn_sqrt_step #(
				.IN_WIDTH      (IN_WIDTH),
				.OUT_FRAC_BITS (OUT_FRAC_BITS),
				.IDX           (R_W - 1 - g),
				.SIDE_W        (SIDE_W)
			) u_step (
				.clk      (clk),
				.en       (en),
				.s_in     (s_c[g]),
				.root_in  (root_c[g]),
				.rem_in   (rem_c[g]),
				.side_in  (side_c[g]),
				.s_out    (s_c[g+1]),
				.root_out (root_c[g+1]),
				.rem_out  (rem_c[g+1]),
				.side_out (side_c[g+1])
			);
		end
	endgenerate

	// Division, three lanes, one quotient bit per stage.
	logic [SIDE_W-1:0]   side_r;
	logic                zero_r;
	logic [R_W-1:0]      m_c   [D_W+1];
	logic [NUM_COMP:0]   flg_c [D_W+1];
	logic [IN_WIDTH-1:0] mag_d [NUM_COMP][D_W+1];
	logic [R_W:0]        rem_d [NUM_COMP][D_W+1];
	logic [Q_W-1:0]      q_d   [NUM_COMP][D_W+1];
	logic                sat_d [NUM_COMP][D_W+1];

	assign side_r   = side_c[R_W];
	assign zero_r   = side_r[SIDE_W-1];
	// A zero vector divides by one.
	assign m_c[0]   = zero_r ? R_W'(1) : root_c[R_W];
	assign flg_c[0] = side_r[SIDE_W-1 -: NUM_COMP+1];

	generate
		for (genvar g = 0; g < D_W; g++) begin : g_div
			always_ff @(posedge clk) begin
				if (en) begin
					m_c[g+1]   <= m_c[g];
					flg_c[g+1] <= flg_c[g];
				end
			end
			for (genvar k = 0; k < NUM_COMP; k++) begin : g_lane
				if (g == 0) begin : g_first
					assign mag_d[k][0] = side_r[k*IN_WIDTH +: IN_WIDTH];
					assign rem_d[k][0] = '0;
					assign q_d[k][0]   = '0;
					assign sat_d[k][0] = 1'b0;
				end
				vn_div_step #(
					.IN_WIDTH      (IN_WIDTH),
					.OUT_FRAC_BITS (OUT_FRAC_BITS),
					.IDX           (D_W - 1 - g)
				) u_step (
					.clk     (clk),
					.en      (en),
					.mag_in  (mag_d[k][g]),
					.m_in    (m_c[g]),
					.rem_in  (rem_d[k][g]),
					.q_in    (q_d[k][g]),
					.sat_in  (sat_d[k][g]),
					.mag_out (mag_d[k][g+1]),
					.rem_out (rem_d[k][g+1]),
					.q_out   (q_d[k][g+1]),
					.sat_out (sat_d[k][g+1])
				);
			end
		end
	endgenerate

	// Output stage: clamp, apply the sign and fit to the field width.
	logic [Q_W-1:0]     qv   [NUM_COMP];
	logic [Q_W-1:0]     sq   [NUM_COMP];
	logic [FIELD_W-1:0] res  [NUM_COMP];
	logic [FIELD_W-1:0] unit_q [NUM_COMP];
	logic               zero_q;

	always_comb begin
		for (int k = 0; k < NUM_COMP; k++) begin
			qv[k]  = sat_d[k][D_W] ? LIMIT : q_d[k][D_W];
			sq[k]  = flg_c[D_W][k] ? (~qv[k] + 1'b1) : qv[k];
			res[k] = FIELD_W'($signed(sq[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_COMP; k++) begin
				unit_q[k] <= res[k];
			end
			zero_q <= flg_c[D_W][NUM_COMP];
		end
	end

	assign unit_x   = unit_q[0];
	assign unit_y   = unit_q[1];
	assign unit_z   = unit_q[2];
	assign was_zero = zero_q;

	// A zero vector must come out as all zero components.
	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_valid && was_zero) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
		else $error("zero vector gave a nonzero component");

	// The divisor entering the dividers is never zero for a live item.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[R_W+2] |-> (m_c[0] != '0))
		else $error("divisor is zero");

	// The first lane's final division remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NV-2] |-> (rem_d[0][D_W] < {1'b0, m_c[D_W]}))
		else $error("division remainder out of range");

endmodule
`default_nettype wire
